>>> design/largest_prime_factor_trial_division_assert.svh
// Assertion macros for the trial division factor block.
`ifndef LARGEST_PRIME_FACTOR_TRIAL_DIVISION_ASSERT_SVH
`define LARGEST_PRIME_FACTOR_TRIAL_DIVISION_ASSERT_SVH
// clocked assertion, disabled while in reset
`define LPFTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// clocked assertion that also holds during reset
`define LPFTD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`endif

>>> design/lpftd_pkg.sv
// Shared constants for the trial division factor block.
package lpftd_pkg;
  localparam logic [1:0] OP_VALUE  = 2'd0;
  localparam logic [1:0] OP_MINUS  = 2'd1;
  localparam logic [1:0] OP_PLUS   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] CLS_HIGH = 2'd0;
  localparam logic [1:0] CLS_MED  = 2'd1;
  localparam logic [1:0] CLS_LOW  = 2'd2;

  localparam int unsigned CFG_DATA_BITS = 64;
  localparam int unsigned CFG_ADDR_BITS = 4;
  localparam logic REG_SMOOTH_BOUND = 1'b0;
  localparam logic [CFG_DATA_BITS-1:0] SMOOTH_BOUND_RESET = '1;
endpackage

>>> design/lpftd_req_if.sv
// Request channel: op and value.
interface lpftd_req_if #(parameter int unsigned VALUE_BITS = 63);
  logic                  valid;
  logic                  ready;
  logic [1:0]            op;
  logic [VALUE_BITS-1:0] value;
  modport source (output valid, op, value, input ready);
  modport sink (input valid, op, value, output ready);
endinterface

>>> design/lpftd_rsp_if.sv
// Result channel: largest factor, bound flag and class.
interface lpftd_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] prime_factor;
  logic        below_bound;
  logic [1:0]  smooth_class;
  modport source (output valid, prime_factor, below_bound, smooth_class, input ready);
  modport sink (input valid, prime_factor, below_bound, smooth_class, output ready);
endinterface

>>> design/largest_prime_factor_trial_division.sv
// Largest prime factor by trial division with a bit-serial divider.
// Usage:
//   req_i carries op and value; a request is taken when valid and ready are
//   both high. ready is high only while no request is in work. rsp_o holds
//   one result per request in an output register and keeps it until taken,
//   so the next request is taken while a result waits.
//   Each trial divides the remaining cofactor by one divisor in a restoring
//   divider that makes one quotient bit per cycle. Divisors are 2, 3, then
//   6k-1 and 6k+1 up to the square root, plus one extra division per prime
//   factor found. The class compares and output load follow in S_CLS1,
//   S_CLS2 and S_CLS3; degenerate operands skip the division and go
//   straight to these states.
//   A stalled receiver holds the last step until the output register frees.
//   smooth_bound is written over the APB port at byte address 0 and resets
//   to all ones; reset drops any request in work and any held result.
module largest_prime_factor_trial_division #(
  parameter int unsigned VALUE_BITS = 63
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  lpftd_req_if.sink                            req_i,
  lpftd_rsp_if.source                          rsp_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lpftd_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [lpftd_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [lpftd_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                 pready
);
  import lpftd_pkg::*;

  localparam int unsigned W  = VALUE_BITS + 1;
  localparam int unsigned CW = $clog2(W);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_CLS1, S_CLS2, S_CLS3} state_e;

  state_e                 state_q;
  logic [CFG_DATA_BITS-1:0] bound_q;
  logic [W-1:0]           r_q, d_q, big_q, quot_q, rem_q;
  logic [VALUE_BITS-1:0]  v_q;
  logic [CW-1:0]          cnt_q;
  logic                   strip_q, gap4_q, degen_q, bb_q, med_q;
  logic [W+3:0]           t10_q;
  logic [W+6:0]           t100_q;
  logic                   out_valid_q, out_bb_q;
  logic [63:0]            out_big_q;
  logic [1:0]             out_cls_q;

  // config port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[3] == REG_SMOOTH_BOUND);
  assign prdata = (paddr[3] == REG_SMOOTH_BOUND) ? bound_q : '0;

  // request decode
  logic [W-1:0] v_ext, operand;
  logic         degen_in;
  always_comb begin
    v_ext = {1'b0, req_i.value};
    case (req_i.op)
      OP_MINUS: begin
        operand  = v_ext - W'(1);
        degen_in = (v_ext <= W'(2));
      end
      OP_PLUS: begin
        operand  = v_ext + W'(1);
        degen_in = (v_ext <= W'(1));
      end
      default: begin
        operand  = v_ext;
        degen_in = (v_ext <= W'(1));
      end
    endcase
  end

  // one restoring division step
  logic [W:0]   rem_sh, rem_sub;
  logic         qbit;
  logic [W-1:0] rem_nx, q_fin;
  logic         last_bit;
  always_comb begin
    rem_sh   = {rem_q, quot_q[W-1]};
    rem_sub  = rem_sh - {1'b0, d_q};
    qbit     = (rem_sh >= {1'b0, d_q});
    rem_nx   = qbit ? rem_sub[W-1:0] : rem_sh[W-1:0];
    q_fin    = {quot_q[W-2:0], qbit};
    last_bit = (cnt_q == CW'(W - 1));
  end

  logic [W-1:0] d_next;
  always_comb begin
    if (d_q == W'(2))      d_next = W'(3);
    else if (d_q == W'(3)) d_next = W'(5);
    else                   d_next = d_q + (gap4_q ? W'(4) : W'(2));
  end

  logic [1:0] cls;
  logic       hi;
  always_comb begin
    hi = (t100_q < (W+7)'(v_q));
    if (degen_q)    cls = CLS_LOW;
    else if (hi)    cls = CLS_HIGH;
    else if (med_q) cls = CLS_MED;
    else            cls = CLS_LOW;
  end

  logic out_free;
  assign out_free = !out_valid_q || rsp_o.ready;

  assign req_i.ready        = (state_q == S_IDLE);
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.prime_factor = out_big_q;
  assign rsp_o.below_bound  = out_bb_q;
  assign rsp_o.smooth_class = out_cls_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bound_q     <= SMOOTH_BOUND_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) bound_q <= pwdata;
      // S_CLS3 handles the output register itself
      if (out_valid_q && rsp_o.ready && (state_q != S_CLS3)) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            v_q     <= req_i.value;
            r_q     <= operand;
            quot_q  <= operand;
            rem_q   <= '0;
            cnt_q   <= '0;
            d_q     <= W'(2);
            gap4_q  <= 1'b0;
            strip_q <= 1'b0;
            big_q   <= W'(1);
            degen_q <= degen_in;
            state_q <= degen_in ? S_CLS1 : S_DIV;
          end
        end
        S_DIV: begin
          if (!last_bit) begin
            rem_q  <= rem_nx;
            quot_q <= q_fin;
            cnt_q  <= cnt_q + CW'(1);
          end else begin
            rem_q <= '0;
            cnt_q <= '0;
            if (!strip_q && (d_q > q_fin)) begin
              // past the root: leftover cofactor is the largest prime
              if (r_q > W'(1)) big_q <= r_q;
              state_q <= S_CLS1;
            end else if (rem_nx == '0) begin
              big_q   <= d_q;
              r_q     <= q_fin;
              quot_q  <= q_fin;
              strip_q <= 1'b1;
            end else begin
              d_q     <= d_next;
              if (d_q != W'(2) && d_q != W'(3)) gap4_q <= !gap4_q;
              quot_q  <= r_q;
              strip_q <= 1'b0;
            end
          end
        end
        S_CLS1: begin
          t10_q   <= ((W+4)'(big_q) << 3) + ((W+4)'(big_q) << 1);
          bb_q    <= degen_q || (64'(big_q) <= bound_q);
          state_q <= S_CLS2;
        end
        S_CLS2: begin
          med_q   <= (t10_q < (W+4)'(v_q));
          t100_q  <= ((W+7)'(t10_q) << 3) + ((W+7)'(t10_q) << 1);
          state_q <= S_CLS3;
        end
        S_CLS3: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_big_q   <= 64'(big_q);
            out_bb_q    <= bb_q;
            out_cls_q   <= cls;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

>>> design/lpftd_checker.sv
// Port-level checks for the trial division factor block, with bind.
`include "largest_prime_factor_trial_division_assert.svh"
module lpftd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] factor_i,
  input logic [1:0]  smooth_class_i
);
  import lpftd_pkg::*;
  `LPFTD_ASSERT(a_busy_after_req, in_valid_i && in_ready_i |=> !in_ready_i, "second request taken")
  `LPFTD_ASSERT(a_valid_hold, out_valid_i && !out_ready_i |=> out_valid_i, "stalled result dropped")
  `LPFTD_ASSERT(a_hold, out_valid_i && !out_ready_i |=> $stable(factor_i), "stalled result changed")
  `LPFTD_ASSERT(a_factor_nonzero, out_valid_i |-> factor_i != 64'd0, "zero factor reported")
  `LPFTD_ASSERT(a_class_code, out_valid_i |-> smooth_class_i <= CLS_LOW, "undefined class code")
endmodule

bind largest_prime_factor_trial_division lpftd_checker u_lpftd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (req_i.valid),
  .in_ready_i     (req_i.ready),
  .out_valid_i    (rsp_o.valid),
  .out_ready_i    (rsp_o.ready),
  .factor_i       (rsp_o.prime_factor),
  .smooth_class_i (rsp_o.smooth_class)
);

>>> tb/sv/tb_largest_prime_factor_trial_division.sv
// Self-checking testbench for the trial division largest prime factor block.
module tb_largest_prime_factor_trial_division;
  import lpftd_pkg::*;

  localparam int unsigned VB = 63;
  localparam longint unsigned CYCLE_LIMIT = 64'd6_000_000;
  localparam longint unsigned VALUE_MAX = 64'h7fff_ffff_ffff_ffff;

  typedef struct packed {
    logic [1:0]    op;
    logic [VB-1:0] value;
  } factor_req_t;

  typedef struct packed {
    logic [63:0] prime_factor;
    logic        below_bound;
    logic [1:0]  smooth_class;
  } factor_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel, penable, pwrite;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [CFG_DATA_BITS-1:0] pwdata, prdata;
  logic pready;

  lpftd_req_if #(.VALUE_BITS(VB)) req_if ();
  lpftd_rsp_if rsp_if ();

  largest_prime_factor_trial_division #(.VALUE_BITS(VB)) u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_if.sink), .rsp_o(rsp_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  factor_req_t pending_reqs[$];
  factor_rsp_t expected_rsps[$];
  logic [63:0] bound_shadow;
  int unsigned mismatches = 0;
  longint unsigned cycles = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  // ---------------------------------------------------------------- predictor
  function automatic logic [63:0] strip_divisor(logic [63:0] r, logic [63:0] d,
                                                inout logic [63:0] big);
    if (r % d == 0) begin
      big = d;
      while (r % d == 0) r = r / d;
    end
    return r;
  endfunction

  function automatic logic [63:0] largest_prime_of(logic [63:0] n);
    logic [63:0] big, r, d, gap;
    big = 64'd1;
    r = n;
    gap = 64'd2;
    if (n <= 1) return 64'd1;
    if (!(64'd2 > r / 2)) r = strip_divisor(r, 64'd2, big);
    if (!(64'd3 > r / 3)) r = strip_divisor(r, 64'd3, big);
    d = 64'd5;
    while (!(d > r / d)) begin
      r = strip_divisor(r, d, big);
      d = d + gap;
      gap = 64'd6 - gap;
    end
    if (r > 1) big = r;
    return big;
  endfunction

  function automatic factor_rsp_t predict_factor(factor_req_t rq, logic [63:0] bound);
    factor_rsp_t rs;
    logic [63:0] v, operand;
    logic degenerate;
    v = {1'b0, rq.value};
    if (rq.op == OP_MINUS) begin
      degenerate = (v <= 2);
      operand = v - 1;
    end else if (rq.op == OP_PLUS) begin
      degenerate = (v <= 1);
      operand = v + 1;
    end else begin
      degenerate = (v <= 1);
      operand = v;
    end
    if (degenerate) begin
      rs.prime_factor = 64'd1;
      rs.below_bound = 1'b1;
      rs.smooth_class = CLS_LOW;
      return rs;
    end
    rs.prime_factor = largest_prime_of(operand);
    rs.below_bound = (rs.prime_factor <= bound);
    if (rs.prime_factor <= (v - 1) / 100) rs.smooth_class = CLS_HIGH;
    else if (rs.prime_factor <= (v - 1) / 10) rs.smooth_class = CLS_MED;
    else rs.smooth_class = CLS_LOW;
    return rs;
  endfunction

  // ---------------------------------------------------------------- driver
  initial begin
    req_if.valid = 1'b0;
    req_if.op = OP_VALUE;
    req_if.value = '0;
    rsp_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && (!req_if.valid || req_if.ready)) begin
      if (gap_left > 0) begin
        req_if.valid <= 1'b0;
        gap_left--;
      end else if (pending_reqs.size() > 0) begin
        factor_req_t rq;
        rq = pending_reqs.pop_front();
        req_if.op <= rq.op;
        req_if.value <= rq.value;
        req_if.valid <= 1'b1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 4);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // receiver: long stretches always ready, others stalling at random
  always @(posedge clk_i) begin
    cycles++;
    if (!rst_ni) rsp_if.ready <= 1'b0;
    else if (cycles[11]) rsp_if.ready <= 1'b1;
    else rsp_if.ready <= ($urandom_range(0, 3) == 0);
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        factor_req_t rq;
        rq.op = req_if.op;
        rq.value = req_if.value;
        expected_rsps.push_back(predict_factor(rq, bound_shadow));
      end
      if (rsp_if.valid && rsp_if.ready) begin
        factor_rsp_t got, want;
        got.prime_factor = rsp_if.prime_factor;
        got.below_bound = rsp_if.below_bound;
        got.smooth_class = rsp_if.smooth_class;
        if (expected_rsps.size() == 0) begin
          if (mismatches < 10) $display("unexpected result: %p", got);
          mismatches++;
        end else begin
          want = expected_rsps.pop_front();
          if (got.prime_factor !== want.prime_factor ||
              got.below_bound !== want.below_bound ||
              got.smooth_class !== want.smooth_class) begin
            if (mismatches < 10)
              $display("mismatch: expected factor %0d flag %0d class %0d, got %0d %0d %0d",
                       want.prime_factor, want.below_bound, want.smooth_class,
                       got.prime_factor, got.below_bound, got.smooth_class);
            mismatches++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  task automatic write_bound(logic [63:0] b);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= b;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    bound_shadow = b;
  endtask

  task automatic push_req(logic [1:0] op, logic [63:0] v);
    factor_req_t rq;
    rq.op = op;
    rq.value = v[VB-1:0];
    pending_reqs.push_back(rq);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_reqs.size() > 0 || req_if.valid || expected_rsps.size() > 0);
  endtask

  // operand = (cofactor up to 40000) * small primes, so trial division stays short
  task automatic push_random_reqs(int unsigned count);
    logic [63:0] n, f;
    int unsigned target, sel;
    logic [63:0] small_primes [6];
    small_primes = '{64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13};
    repeat (count) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        push_req(2'($urandom_range(0, 3)), 64'($urandom_range(0, 5000)));
      end else begin
        n = 64'($urandom_range(2, 40000));
        target = $urandom_range(8, 62);
        while (n < (64'd1 << target)) begin
          f = small_primes[$urandom_range(0, 5)];
          if (n > (VALUE_MAX - 1) / f) break;
          n = n * f;
        end
        case ($urandom_range(0, 3))
          0: push_req(OP_VALUE, n);
          1: push_req(OP_MINUS, n + 1);
          2: push_req(OP_PLUS, n - 1);
          default: push_req(OP_UNUSED, n);
        endcase
      end
    end
  endtask

  initial begin
    bound_shadow = SMOOTH_BOUND_RESET;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_bound('1);

    // degenerate operands
    push_req(OP_VALUE, 64'd0);
    push_req(OP_VALUE, 64'd1);
    push_req(OP_MINUS, 64'd0);
    push_req(OP_MINUS, 64'd1);
    push_req(OP_MINUS, 64'd2);
    push_req(OP_PLUS, 64'd0);
    push_req(OP_PLUS, 64'd1);
    // smallest real operands and the unused op code
    push_req(OP_VALUE, 64'd2);
    push_req(OP_MINUS, 64'd3);
    push_req(OP_PLUS, 64'd2);
    push_req(OP_UNUSED, 64'd10);
    // widest values: operand of 2^63 needs all 64 operand bits
    push_req(OP_PLUS, VALUE_MAX);
    push_req(OP_VALUE, 64'h4000_0000_0000_0000);
    push_req(OP_MINUS, 64'h4000_0000_0000_0001);
    push_req(OP_VALUE, 64'd4052555153018976267);
    // prime cofactor left over, and the class boundaries
    push_req(OP_VALUE, 64'd39989);
    push_req(OP_VALUE, 64'd1000);
    push_req(OP_VALUE, 64'd1001);
    push_req(OP_VALUE, 64'd100);
    push_req(OP_VALUE, 64'd101 * 64'd1024);
    push_req(OP_PLUS, 64'd1048575);
    wait_drained();

    push_random_reqs(20);
    wait_drained();
    write_bound('0);
    push_random_reqs(20);
    wait_drained();
    write_bound(64'($urandom_range(2, 50000)));
    push_random_reqs(20);
    wait_drained();
    write_bound({$urandom, $urandom});
    push_random_reqs(20);
    wait_drained();

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
